@@ rtl/substring_search_case_fold_core_macros.svh @@
// ----------------------------------------------------------------------------
// substring_search_case_fold_core_macros
// Assertion macros used by the substring search window (ssc_window).
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_SEARCH_CASE_FOLD_CORE_MACROS_SVH
`define SUBSTRING_SEARCH_CASE_FOLD_CORE_MACROS_SVH

// property checked on every rising edge of clk_i outside reset
`define SSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition that must never be seen outside reset
`define SSC_ASSERT_NEVER(lbl, expr, msg) \
  `SSC_ASSERT(lbl, !(expr), msg)

`endif

@@ rtl/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssc_pkg
// Types and constants shared by the substring search blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int BYTE_W    = 8;
  localparam int POS_W     = 16;
  localparam int LEN_W     = 5;
  localparam int WORD_W    = 64;
  localparam int WIN_MAX   = 16;
  localparam int ADDR_W    = 6;
  localparam int REG_IDX_W = 3;
  localparam int REG_LSB   = 3;

  // register indexes, one 64-bit slot each
  localparam logic [REG_IDX_W-1:0] REG_NEEDLE_LO  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NEEDLE_HI  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NEEDLE_LEN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FOLD_CASE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START_OFS  = 3'd4;

  localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] ASCII_CASE    = 8'h20;

  typedef struct packed {
    logic [WORD_W-1:0] needle_lo;
    logic [WORD_W-1:0] needle_hi;
    logic [LEN_W-1:0]  needle_length;
    logic              fold_case;
    logic [POS_W-1:0]  start_offset;
  } ssc_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] haystack_byte;
    logic              last_byte;
  } ssc_item_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [POS_W-1:0] match_position;
  } ssc_res_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                   input logic en);
    logic [BYTE_W-1:0] r;
    r = c;
    if (en && c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
      r = c - ASCII_CASE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ssc_if.sv @@
// ----------------------------------------------------------------------------
// ssc_if
// Valid/ready channels for haystack bytes and search results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssc_in_if;
  logic                      valid;
  logic                      ready;
  logic [ssc_pkg::BYTE_W-1:0] haystack_byte;
  logic                      last_byte;

  modport source(output valid, haystack_byte, last_byte, input ready);
  modport sink(input valid, haystack_byte, last_byte, output ready);
endinterface

interface ssc_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [ssc_pkg::POS_W-1:0] match_position;

  modport source(output valid, found, match_position, input ready);
  modport sink(input valid, found, match_position, output ready);
endinterface

`default_nettype wire

@@ rtl/ssc_cfg.sv @@
// ----------------------------------------------------------------------------
// ssc_cfg
// APB register file holding needle, length, case fold and start offset.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ssc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ssc_pkg::WORD_W-1:0]   pwdata,
  output logic      [ssc_pkg::WORD_W-1:0]   prdata,
  output logic                              pready,
  output ssc_pkg::ssc_cfg_t                 cfg_o
);

  logic [ssc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;
  ssc_pkg::ssc_cfg_t             cfg_q;

  assign reg_idx = paddr[ssc_pkg::REG_LSB +: ssc_pkg::REG_IDX_W];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        ssc_pkg::REG_NEEDLE_LO:  cfg_q.needle_lo <= pwdata;
        ssc_pkg::REG_NEEDLE_HI:  cfg_q.needle_hi <= pwdata;
        ssc_pkg::REG_NEEDLE_LEN: cfg_q.needle_length <= pwdata[ssc_pkg::LEN_W-1:0];
        ssc_pkg::REG_FOLD_CASE:  cfg_q.fold_case <= pwdata[0];
        ssc_pkg::REG_START_OFS:  cfg_q.start_offset <= pwdata[ssc_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      ssc_pkg::REG_NEEDLE_LO:  prdata = cfg_q.needle_lo;
      ssc_pkg::REG_NEEDLE_HI:  prdata = cfg_q.needle_hi;
      ssc_pkg::REG_NEEDLE_LEN: prdata = ssc_pkg::WORD_W'(cfg_q.needle_length);
      ssc_pkg::REG_FOLD_CASE:  prdata = ssc_pkg::WORD_W'(cfg_q.fold_case);
      ssc_pkg::REG_START_OFS:  prdata = ssc_pkg::WORD_W'(cfg_q.start_offset);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/ssc_window.sv @@
// ----------------------------------------------------------------------------
// ssc_window
// Byte window, string position and match state with the needle compare.
// ----------------------------------------------------------------------------
`default_nettype none

`include "substring_search_case_fold_core_macros.svh"

module ssc_window #(
  parameter int              MAX_NEEDLE_LENGTH = 16,
  parameter longint unsigned MAX_STRING_LENGTH = 65536
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ssc_pkg::ssc_cfg_t  cfg_i,
  input  wire ssc_pkg::ssc_item_t item_i,
  input  wire logic               adv_i,
  output ssc_pkg::ssc_res_t       res_o
);

  localparam int WinD     = (MAX_NEEDLE_LENGTH < ssc_pkg::WIN_MAX) ?
                            MAX_NEEDLE_LENGTH : ssc_pkg::WIN_MAX;
  localparam int WinIdxW  = (WinD > 1) ? $clog2(WinD) : 1;
  localparam int IdxW     = $clog2(MAX_STRING_LENGTH + 1);
  localparam int CmpW     = (IdxW > ssc_pkg::POS_W + 1) ? IdxW : ssc_pkg::POS_W + 1;

  logic [ssc_pkg::BYTE_W-1:0]   recent_q [WinD];
  logic [ssc_pkg::BYTE_W-1:0]   win      [WinD];
  logic [IdxW-1:0]              idx_q;
  logic                         reported_q;

  logic [2*ssc_pkg::WORD_W-1:0] needle;
  logic [WinD-1:0]              hit_vec;
  logic                         len_ok;
  logic                         in_range;
  logic                         idx_ok;
  logic                         start_ok;
  logic                         found;
  logic [CmpW-1:0]              idx_w;
  logic [CmpW-1:0]              len_w;
  logic [CmpW-1:0]              start;

  assign needle = {cfg_i.needle_hi, cfg_i.needle_lo};

  // window as it stands once the current byte is shifted in
  always_comb begin
    win[0] = item_i.haystack_byte;
    for (int k = 1; k < WinD; k++) begin
      win[k] = recent_q[k-1];
    end
  end

  // needle byte j lines up with the byte len-1-j places back
  always_comb begin
    logic [ssc_pkg::LEN_W-1:0] sel;
    for (int j = 0; j < WinD; j++) begin
      sel = cfg_i.needle_length - ssc_pkg::LEN_W'(j) - ssc_pkg::LEN_W'(1);
      hit_vec[j] = (ssc_pkg::LEN_W'(j) >= cfg_i.needle_length) ||
                   (ssc_pkg::fold_byte(win[sel[WinIdxW-1:0]], cfg_i.fold_case) ==
                    ssc_pkg::fold_byte(needle[j*ssc_pkg::BYTE_W +: ssc_pkg::BYTE_W],
                                       cfg_i.fold_case));
    end
  end

  assign idx_w    = CmpW'(idx_q);
  assign len_w    = CmpW'(cfg_i.needle_length);
  assign start    = idx_w + CmpW'(1) - len_w;
  assign len_ok   = (cfg_i.needle_length != '0) &&
                    (cfg_i.needle_length <= ssc_pkg::LEN_W'(WinD));
  assign in_range = idx_q < IdxW'(MAX_STRING_LENGTH);
  assign idx_ok   = (idx_w + CmpW'(1)) >= len_w;
  assign start_ok = (start >= CmpW'(cfg_i.start_offset)) &&
                    (start <= CmpW'({ssc_pkg::POS_W{1'b1}}));
  assign found    = !reported_q && len_ok && in_range && idx_ok && start_ok && (&hit_vec);

  assign res_o.valid          = found || (item_i.last_byte && !reported_q);
  assign res_o.found          = found;
  assign res_o.match_position = found ? start[ssc_pkg::POS_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      reported_q <= 1'b0;
      for (int k = 0; k < WinD; k++) begin
        recent_q[k] <= '0;
      end
    end else if (adv_i) begin
      if (item_i.last_byte) begin
        idx_q      <= '0;
        reported_q <= 1'b0;
        for (int k = 0; k < WinD; k++) begin
          recent_q[k] <= '0;
        end
      end else begin
        reported_q <= reported_q || found;
        if (in_range) begin
          idx_q <= idx_q + IdxW'(1);
        end
        for (int k = 0; k < WinD; k++) begin
          recent_q[k] <= win[k];
        end
      end
    end
  end

  `SSC_ASSERT(a_rearm_on_last, (adv_i && item_i.last_byte) |=> (idx_q == '0 && !reported_q), "string state not cleared after last byte")
  `SSC_ASSERT_NEVER(a_idx_bound, idx_q > IdxW'(MAX_STRING_LENGTH), "byte index past bound")
  `SSC_ASSERT(a_found_after_ofs, res_o.found |-> (res_o.match_position >= cfg_i.start_offset), "match before start offset")
  `SSC_ASSERT(a_one_match, (adv_i && found && !item_i.last_byte) |=> (reported_q && !res_o.found), "second match in one string")

endmodule

`default_nettype wire

@@ rtl/substring_search_case_fold_core.sv @@
// ----------------------------------------------------------------------------
// substring_search_case_fold_core
// Streaming substring search with optional ASCII case folding.
// ----------------------------------------------------------------------------
// Takes one haystack byte per cycle, unless a result waits on a stalled output,
// and reports, per string, either the start index of the first needle match
// (found=1) on the byte that completes it, or not found (found=0, position 0)
// on the byte flagged last. The byte lands in an input register, the window
// compare of up to 16 needle bytes is combinational, and the result is held in
// an output register. The combinational window compare sets the rate of one
// byte a cycle. No clearing pass follows reset. Registers sit at byte address
// 8*i over a 64-bit APB data path; write them only while the block is idle.
`default_nettype none

module substring_search_case_fold_core #(
  parameter int              MAX_NEEDLE_LENGTH = 16,
  parameter longint unsigned MAX_STRING_LENGTH = 65536
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  ssc_in_if.sink                          in_i,
  ssc_out_if.source                       out_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssc_pkg::WORD_W-1:0] pwdata,
  output logic      [ssc_pkg::WORD_W-1:0] prdata,
  output logic                            pready
);

  ssc_pkg::ssc_cfg_t  cfg;
  ssc_pkg::ssc_item_t item_q;
  ssc_pkg::ssc_res_t  res;
  ssc_pkg::ssc_res_t  out_q;
  logic               item_vld_q;
  logic               adv;
  logic               in_take;

  ssc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssc_window #(
    .MAX_NEEDLE_LENGTH (MAX_NEEDLE_LENGTH),
    .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item_q),
    .adv_i  (adv),
    .res_o  (res)
  );

  // an item without a result moves on even while the output is stalled
  assign adv        = item_vld_q && (!res.valid || !out_q.valid || out_o.ready);
  assign in_i.ready = !item_vld_q || adv;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_take) begin
      item_vld_q <= 1'b1;
    end else if (adv) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.haystack_byte <= in_i.haystack_byte;
      item_q.last_byte     <= in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (adv && res.valid) begin
      out_q <= res;
    end else if (out_o.ready) begin
      out_q.valid <= 1'b0;
    end
  end

  assign out_o.valid          = out_q.valid;
  assign out_o.found          = out_q.found;
  assign out_o.match_position = out_q.match_position;

endmodule

`default_nettype wire
